[rtl/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants for the learning switch forwarder
// Field widths, verdict codes, sequencer states and the port-to-mask helper.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // Field widths of the frame and result transfers.
  localparam int MAC_W   = 48;
  localparam int PORT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int MASK_W  = 16;
  localparam int ENTRY_W = MAC_W + PORT_W;

  // Defaults and limits.
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int MAX_PORTS         = 16;
  localparam logic [PORT_W-1:0] ACTIVE_PORTS_RST = PORT_W'(16);

  // Forwarding decision codes.
  typedef enum logic [1:0] {
    VERDICT_CSUM_ERR  = 2'd0,
    VERDICT_UNICAST   = 2'd1,
    VERDICT_DROP_SAME = 2'd2,
    VERDICT_BCAST     = 2'd3
  } verdict_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC_RD,
    S_SRC_CMP,
    S_LEARN,
    S_DST_RD,
    S_DST_CMP,
    S_DONE
  } state_t;

  // One-hot mask bit for a port numbered from one; ports outside the mask give zero.
  function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] port);
    logic [MASK_W-1:0] bits;
    bits = '0;
    for (int i = 1; i <= MASK_W; i++) begin
      if (port == PORT_W'(i)) begin
        bits[i-1] = 1'b1;
      end
    end
    return bits;
  endfunction

endpackage

[rtl/lsf_if.sv]
// ----------------------------------------------------------------------------
// lsf_if: valid/ready channels of the learning switch forwarder
// lsf_in_if carries frame items; lsf_out_if carries forwarding results.
// ----------------------------------------------------------------------------
interface lsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [lsf_pkg::MAC_W-1:0]   src_mac;
  logic [lsf_pkg::MAC_W-1:0]   dst_mac;
  logic [lsf_pkg::PORT_W-1:0]  in_port;
  logic [lsf_pkg::BYTE_W-1:0]  payload_byte;
  logic                        byte_present;
  logic                        frame_end;
  logic [lsf_pkg::BYTE_W-1:0]  carried_checksum;

  modport source (
    output valid, src_mac, dst_mac, in_port, payload_byte, byte_present,
           frame_end, carried_checksum,
    input  ready
  );
  modport sink (
    input  valid, src_mac, dst_mac, in_port, payload_byte, byte_present,
           frame_end, carried_checksum,
    output ready
  );
endinterface

interface lsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  verdict;
  logic [lsf_pkg::PORT_W-1:0]  egress_port;
  logic [lsf_pkg::MASK_W-1:0]  egress_mask;
  logic                        source_learned;
  logic                        table_full;
  logic [lsf_pkg::BYTE_W-1:0]  computed_checksum;

  modport source (
    output valid, verdict, egress_port, egress_mask, source_learned, table_full,
           computed_checksum,
    input  ready
  );
  modport sink (
    input  valid, verdict, egress_port, egress_mask, source_learned, table_full,
           computed_checksum,
    output ready
  );
endinterface

[rtl/lsf_ram.sv]
// ----------------------------------------------------------------------------
// lsf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/learning_switch_forwarder.sv]
// ----------------------------------------------------------------------------
// learning_switch_forwarder: learning bridge with a MAC station table
// Sums payload bytes per frame, learns source MACs and forwards on frame end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Contents
//  in_if     sink       valid/ready      MACs, ingress port, byte, flags, checksum
//  out_if    source     valid/ready      verdict, egress port/mask, flags, sum
//  cfg_*     sink       write enable     active_ports register
//
//  Items without frame_end are taken back to back; ready stays high between frames.
//  A frame end is taken, then the sequencer runs the source search, the learn
//  state, the destination search (skipped on a checksum mismatch) and the done
//  state, which hands over the result once the output register is free; every
//  search step reads one filled entry through the one table read port.
//  Reset clears the sum and the fill count and sets active_ports to 16; the
//  table is never cleared, since only filled entries are read.
//  A stalled result sits in the output register while later items of the next
//  frame are still taken; the result of a further frame end waits in the
//  sequencer, with the input held off, until the stalled one leaves.
//
module learning_switch_forwarder #(
  parameter int TABLE_ENTRIES = lsf_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lsf_in_if.sink                      in_if,
  lsf_out_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [lsf_pkg::PORT_W-1:0]  cfg_wdata
);
  import lsf_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;

  logic [PORT_W-1:0] active_ports_r;
  logic [BYTE_W-1:0] running_sum_r;
  logic [CW-1:0]     used_r;
  logic [CW-1:0]     idx_r;

  // Frame fields latched at frame end.
  logic [MAC_W-1:0]  src_r, dst_r;
  logic [PORT_W-1:0] port_r;
  logic [BYTE_W-1:0] carried_r, sum_r;

  // Working result.
  logic              src_found_r;
  verdict_t          verdict_r;
  logic [PORT_W-1:0] egress_r;
  logic [MASK_W-1:0] mask_r;
  logic              learned_r, full_r;

  // Output register.
  logic              out_valid_r;
  verdict_t          out_verdict_r;
  logic [PORT_W-1:0] out_egress_r;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_learned_r, out_full_r;
  logic [BYTE_W-1:0] out_sum_r;

  // Control and datapath signals.
  logic              in_fire;
  logic              out_load;
  logic              ram_we;
  logic [ENTRY_W-1:0] rd_entry;
  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;
  logic [MAC_W-1:0]  key;
  logic              key_match;
  logic              scan_end;
  logic              has_room;
  logic [BYTE_W-1:0] sum_now;
  logic [PORT_W-1:0] limit;
  logic [MASK_W-1:0] bcast_mask;

  // Station table.
  lsf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used_r[AW-1:0]),
    .wdata ({port_r, src_r}),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_entry)
  );

  assign rd_mac  = rd_entry[MAC_W-1:0];
  assign rd_port = rd_entry[ENTRY_W-1:MAC_W];

  // Shared MAC comparator, keyed by the search in progress.
  assign key       = (state_r == S_DST_CMP) ? dst_r : src_r;
  assign key_match = (rd_mac == key);
  assign scan_end  = (idx_r == used_r);
  assign has_room  = (used_r < CW'(TABLE_ENTRIES));

  // Running byte sum including the current item.
  assign sum_now = running_sum_r + (in_if.byte_present ? in_if.payload_byte : '0);

  // Broadcast mask: every active port except the ingress port.
  always_comb begin
    limit = (active_ports_r > PORT_W'(MAX_PORTS)) ? PORT_W'(MAX_PORTS) : active_ports_r;
    bcast_mask = '0;
    for (int i = 1; i <= MASK_W; i++) begin
      bcast_mask[i-1] = (PORT_W'(i) <= limit) && (PORT_W'(i) != port_r);
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_if.frame_end) begin
          state_nxt = S_SRC_RD;
        end
      end
      S_SRC_RD: begin
        state_nxt = scan_end ? S_LEARN : S_SRC_CMP;
      end
      S_SRC_CMP: begin
        state_nxt = key_match ? S_LEARN : S_SRC_RD;
      end
      S_LEARN: begin
        state_nxt = (carried_r != sum_r) ? S_DONE : S_DST_RD;
      end
      S_DST_RD: begin
        state_nxt = scan_end ? S_DONE : S_DST_CMP;
      end
      S_DST_CMP: begin
        state_nxt = key_match ? S_DONE : S_DST_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_if.ready = (state_r == S_IDLE);
    ram_we      = (state_r == S_LEARN) && !src_found_r && has_room;
    out_load    = (state_r == S_DONE) && (!out_valid_r || out_if.ready);
  end

  assign in_fire = in_if.valid && in_if.ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_ports_r <= ACTIVE_PORTS_RST;
    end else if (cfg_we) begin
      active_ports_r <= cfg_wdata;
    end
  end

  // Byte sum and table fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      used_r        <= '0;
    end else begin
      if (in_fire) begin
        running_sum_r <= in_if.frame_end ? '0 : sum_now;
      end
      if (ram_we) begin
        used_r <= used_r + CW'(1);
      end
    end
  end

  // Frame capture, search index and decision.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        src_r       <= in_if.src_mac;
        dst_r       <= in_if.dst_mac;
        port_r      <= in_if.in_port;
        carried_r   <= in_if.carried_checksum;
        sum_r       <= sum_now;
        idx_r       <= '0;
        src_found_r <= 1'b0;
        learned_r   <= 1'b0;
        full_r      <= 1'b0;
        verdict_r   <= VERDICT_CSUM_ERR;
        egress_r    <= '0;
        mask_r      <= '0;
      end
      S_SRC_CMP: begin
        if (key_match) begin
          src_found_r <= 1'b1;
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      S_LEARN: begin
        idx_r     <= '0;
        learned_r <= ram_we;
        full_r    <= !src_found_r && !has_room;
      end
      S_DST_RD: begin
        if (scan_end) begin
          verdict_r <= VERDICT_BCAST;
          mask_r    <= bcast_mask;
        end
      end
      S_DST_CMP: begin
        if (key_match) begin
          if (rd_port == port_r) begin
            verdict_r <= VERDICT_DROP_SAME;
          end else begin
            verdict_r <= VERDICT_UNICAST;
            egress_r  <= rd_port;
            mask_r    <= port_bit(rd_port);
          end
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict_r <= verdict_r;
      out_egress_r  <= egress_r;
      out_mask_r    <= mask_r;
      out_learned_r <= learned_r;
      out_full_r    <= full_r;
      out_sum_r     <= sum_r;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.verdict           = out_verdict_r;
  assign out_if.egress_port       = out_egress_r;
  assign out_if.egress_mask       = out_mask_r;
  assign out_if.source_learned    = out_learned_r;
  assign out_if.table_full        = out_full_r;
  assign out_if.computed_checksum = out_sum_r;

endmodule

[rtl/lsf_checker.sv]
// ----------------------------------------------------------------------------
// lsf_checker: port-level assertions for the learning switch forwarder
// Watches the channel ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_frame_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_verdict,
  input logic [lsf_pkg::PORT_W-1:0]  out_egress_port,
  input logic [lsf_pkg::MASK_W-1:0]  out_egress_mask,
  input logic                        out_source_learned,
  input logic                        out_table_full
);
  import lsf_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A frame end starts the table search, so the input is busy next cycle.
  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end |=> !in_ready)
    else $error("input ready right after a frame end transfer");

  // Only a unicast names an egress port.
  a_port_unicast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != VERDICT_UNICAST) |-> (out_egress_port == '0))
    else $error("egress port set on a non-unicast result");

  // Discarded and dropped frames go nowhere.
  a_mask_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_verdict == VERDICT_CSUM_ERR) || (out_verdict == VERDICT_DROP_SAME))
    |-> (out_egress_mask == '0))
    else $error("egress mask set on a discarded or dropped frame");

  // A source is never both learned and reported as not fitting.
  a_learn_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_source_learned && out_table_full))
    else $error("source learned and table full on the same result");

endmodule

bind learning_switch_forwarder lsf_checker u_lsf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_frame_end       (in_if.frame_end),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_verdict        (out_if.verdict),
  .out_egress_port    (out_if.egress_port),
  .out_egress_mask    (out_if.egress_mask),
  .out_source_learned (out_if.source_learned),
  .out_table_full     (out_if.table_full)
);
